// ===== rtl/core/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants for the byte set table
// Request codes, default capacity and the per-cell control word.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int MaxMembersDefault = 32;
    localparam int ElemW             = 8;
    localparam int CountOutW         = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic             write_en;
        logic             shift_en;
        logic [ElemW-1:0] element;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bst_if.sv =====
// ----------------------------------------------------------------------------
// bst_if: request and response channels of the byte set table
// Valid/ready handshake; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bst_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] element;

    modport source (output valid, output opcode, output element, input ready);
    modport sink   (input valid, input opcode, input element, output ready);
endinterface

interface bst_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] member_count;
    logic       is_empty;
    logic       is_full;
    logic       status;

    modport source (output valid, output found, output member_count,
                    output is_empty, output is_full, output status, input ready);
    modport sink   (input valid, input found, input member_count,
                    input is_empty, input is_full, input status, output ready);
endinterface

// ===== rtl/core/bst_cell.sv =====
// ----------------------------------------------------------------------------
// bst_cell: one entry of the packed member row
// Holds one byte, compares it with the request and passes its byte down.
// ----------------------------------------------------------------------------
module bst_cell
    import bst_pkg::*;
#(
    parameter int CNT_W = 6,
    parameter int INDEX = 0
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic                 match_in,
    input  logic [ElemW-1:0]     upper_value,
    output logic                 match_out,
    output logic [ElemW-1:0]     value
);

    logic [ElemW-1:0] entry_reg;
    logic [ElemW-1:0] entry_next;
    logic             live;
    logic             at_tail;

    assign live    = (CNT_W'(INDEX) < count);
    assign at_tail = (CNT_W'(INDEX) == count);

    // Match at or below this place: from here on the row closes the gap
    assign match_out = match_in | (live & (entry_reg == ctrl.element));
    assign value     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write_en && at_tail)
        begin
            entry_next = ctrl.element;
        end
        else if (ctrl.shift_en && match_out)
        begin
            entry_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/byte_set_table.sv =====
// ----------------------------------------------------------------------------
// byte_set_table: set of distinct bytes held as a packed row with a count
// Insert, delete, lookup and clear; one response word per request word.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | opcode[1:0], element[7:0]
//  rsp     | out | found, member_count[5:0], is_empty, is_full, status
//
//  One request per cycle: every cell compares and shifts in the cycle the
//  request is taken, and the response is registered for the next cycle.
//  The count resets to zero; entries at and above the count never match.
//  A held response stalls the request side only when rsp.ready is low.
// ----------------------------------------------------------------------------
module byte_set_table
    import bst_pkg::*;
#(
    parameter int MAX_MEMBERS = MaxMembersDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    bst_req_if.sink      req,
    bst_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              found_reg;
    logic [5:0]        member_count_reg;
    logic              is_empty_reg;
    logic              is_full_reg;
    logic              status_reg;

    logic              take;
    logic              hit;
    logic              full_now;
    logic              reject;
    opcode_t           op;
    cell_ctrl_t        ctrl;
    logic [CNT_W+5:0]  count_wide;

    logic [ElemW-1:0]  cell_value [MAX_MEMBERS];
    logic [ElemW-1:0]  cell_upper [MAX_MEMBERS];
    logic              match_chain [MAX_MEMBERS+1];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign op        = opcode_t'(req.opcode);
    assign full_now  = (count_reg == CNT_W'(MAX_MEMBERS));
    assign hit       = match_chain[MAX_MEMBERS];
    assign reject    = (op == OP_INSERT) && !hit && full_now;

    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_MEMBERS; gi++)
        begin : g_cell
            if (gi == MAX_MEMBERS - 1)
            begin : g_top
                assign cell_upper[gi] = cell_value[gi];
            end
            else
            begin : g_mid
                assign cell_upper[gi] = cell_value[gi+1];
            end

            bst_cell #(
                .CNT_W (CNT_W),
                .INDEX (gi)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .match_in    (match_chain[gi]),
                .upper_value (cell_upper[gi]),
                .match_out   (match_chain[gi+1]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.write_en = 1'b0;
        ctrl.shift_en = 1'b0;
        ctrl.element  = req.element;
        count_next    = count_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (take && !hit && !full_now)
                begin
                    ctrl.write_en = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                ctrl.shift_en = take;
                if (take && hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
            end
            OP_CLEAR:
            begin
                if (take)
                begin
                    count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Widen before cutting to the 6-bit field; a count above 63 keeps its low six bits
    assign count_wide = {6'd0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg        <= hit;
            member_count_reg <= count_wide[5:0];
            is_empty_reg     <= (count_next == '0);
            is_full_reg      <= (count_next == CNT_W'(MAX_MEMBERS));
            status_reg       <= reject;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.found        = found_reg;
    assign rsp.member_count = member_count_reg;
    assign rsp.is_empty     = is_empty_reg;
    assign rsp.is_full      = is_full_reg;
    assign rsp.status       = status_reg;

endmodule
